### design/fcce_pkg.sv
`default_nettype none
package fcce_pkg;

    localparam int NUM_TAPS   = 7;
    localparam int HALF_WIN   = NUM_TAPS / 2;
    localparam int HIST_DEPTH = 2 * HALF_WIN;
    localparam int SAT_COUNT  = HALF_WIN + 1;

    localparam int SMP_W  = 16;
    localparam int COEF_W = 16;
    localparam int PROD_W = SMP_W + COEF_W;
    localparam int SUM_W  = 34;
    localparam int CNT_W  = 3;
    localparam int ADDR_W = 3;
    localparam int FK_W   = 2;

    localparam logic [CNT_W-1:0] HALF_CNT = CNT_W'(HALF_WIN);
    localparam logic [CNT_W-1:0] SAT_CNT  = CNT_W'(SAT_COUNT);
    localparam logic [FK_W-1:0]  LAST_FK  = FK_W'(HALF_WIN);

    localparam logic [NUM_TAPS-1:0][COEF_W-1:0] COEF_RESET = {
        16'sd1966, 16'sd1999, 16'sd7930, 16'sd12550, 16'sd7930, 16'sd1999, 16'sd1966
    };

    // One window of samples headed for the MAC: smp[0] oldest, smp[6] newest.
    typedef struct packed {
        logic                              valid;
        logic                              last;
        logic [NUM_TAPS-1:0][SMP_W-1:0]    smp;
    } t_win;

    typedef struct packed {
        logic flush;
    } t_stat;

endpackage
`default_nettype wire

### design/fcce_window.sv
`default_nettype none
module fcce_window
    import fcce_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [SMP_W-1:0] i_sample,
    input  wire logic             i_final,
    output logic                  o_ready,
    input  wire logic             i_take,
    output t_win                  o_win,
    output t_stat                 o_stat
);

    logic [HIST_DEPTH-1:0][SMP_W-1:0] r_hist, n_hist;
    logic [CNT_W-1:0]                 r_cnt, n_cnt;
    logic                             r_flush, n_flush;
    logic [FK_W-1:0]                  r_fk, n_fk;
    logic [SMP_W-1:0]                 r_fx, n_fx;
    logic [CNT_W-1:0]                 r_fc, n_fc;
    t_win                             r_s1, n_s1;

    logic                             s1_free;
    logic                             acc;
    logic [HIST_DEPTH-1:0][SMP_W-1:0] hist_eff;
    logic [CNT_W-1:0]                 flush_pos;

    assign s1_free   = !r_s1.valid || i_take;
    assign o_ready   = s1_free && !r_flush;
    assign acc       = i_valid && o_ready;
    assign flush_pos = r_fc + {{(CNT_W-FK_W){1'b0}}, r_fk};

    // first sample of a run stands in for everything before it
    always_comb begin
        for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_eff[k] = (r_cnt == '0) ? i_sample : r_hist[k];
        end
    end

    always_comb begin
        n_hist  = r_hist;
        n_cnt   = r_cnt;
        n_flush = r_flush;
        n_fk    = r_fk;
        n_fx    = r_fx;
        n_fc    = r_fc;
        n_s1    = r_s1;
        if (s1_free) begin
            n_s1.valid = 1'b0;
        end
        if (acc) begin
            n_s1.valid = (r_cnt >= HALF_CNT);
            n_s1.last  = 1'b0;
            n_s1.smp   = {i_sample, hist_eff};
            n_hist     = {i_sample, hist_eff[HIST_DEPTH-1:1]};
            if (i_final) begin
                n_flush = 1'b1;
                n_fk    = FK_W'(1);
                n_fx    = i_sample;
                n_fc    = r_cnt;
                n_cnt   = '0;
            end else if (r_cnt < SAT_CNT) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end else if (r_flush && s1_free) begin
            // tail: keep repeating the final sample past the end
            n_s1.valid = (flush_pos >= HALF_CNT);
            n_s1.last  = (r_fk == LAST_FK);
            n_s1.smp   = {r_fx, r_hist};
            n_hist     = {r_fx, r_hist[HIST_DEPTH-1:1]};
            if (r_fk == LAST_FK) begin
                n_flush = 1'b0;
            end else begin
                n_fk = r_fk + FK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= '0;
            r_cnt    <= '0;
            r_flush  <= 1'b0;
            r_fk     <= '0;
            r_s1.valid <= 1'b0;
        end else begin
            r_hist   <= n_hist;
            r_cnt    <= n_cnt;
            r_flush  <= n_flush;
            r_fk     <= n_fk;
            r_s1.valid <= n_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fx      <= n_fx;
        r_fc      <= n_fc;
        r_s1.last <= n_s1.last;
        r_s1.smp  <= n_s1.smp;
    end

    assign o_win        = r_s1;
    assign o_stat.flush = r_flush;

endmodule
`default_nettype wire

### design/fcce_mac.sv
`default_nettype none
module fcce_mac
    import fcce_pkg::*;
(
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [NUM_TAPS-1:0][COEF_W-1:0] i_coef,
    input  t_win                                 i_win,
    output logic                                 o_take,
    output logic                                 o_valid,
    output logic                                 o_last,
    output logic [SUM_W-1:0]                     o_sum,
    input  wire logic                            i_ready
);

    logic                              r_pv, r_pl;
    logic [NUM_TAPS-1:0][PROD_W-1:0]   r_prod;
    logic                              r_av, r_al;
    logic [SUM_W-1:0]                  r_pa, r_pb;
    logic                              r_ov, r_ol;
    logic [SUM_W-1:0]                  r_osum;

    logic                              s2_free, s3_free, s4_free;
    logic [NUM_TAPS-1:0][PROD_W-1:0]   prod;
    logic [NUM_TAPS-1:0][SUM_W-1:0]    pext;

    assign s4_free = !r_ov || i_ready;
    assign s3_free = !r_av || s4_free;
    assign s2_free = !r_pv || s3_free;
    assign o_take  = s2_free;

    always_comb begin
        for (int t = 0; t < NUM_TAPS; t++) begin
            prod[t] = PROD_W'($signed(i_coef[t]) * $signed(i_win.smp[t]));
            pext[t] = {{(SUM_W-PROD_W){r_prod[t][PROD_W-1]}}, r_prod[t]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_av <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (s2_free) begin
                r_pv <= i_win.valid;
            end
            if (s3_free) begin
                r_av <= r_pv;
            end
            if (s4_free) begin
                r_ov <= r_av;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free) begin
            r_pl   <= i_win.last;
            r_prod <= prod;
        end
        if (s3_free) begin
            r_al <= r_pl;
            r_pa <= pext[0] + pext[1] + pext[2] + pext[3];
            r_pb <= pext[4] + pext[5] + pext[6];
        end
        if (s4_free) begin
            r_ol   <= r_al;
            r_osum <= r_pa + r_pb;
        end
    end

    assign o_valid = r_ov;
    assign o_last  = r_ol;
    assign o_sum   = r_osum;

endmodule
`default_nettype wire

### design/fir_convolution_clamped_edges_unit.sv
`default_nettype none
// Channel     | Dir | Payload                                  | Handshake
// ------------+-----+------------------------------------------+-------------------
// s_axis      | in  | tdata[15:0] sample, tlast final_sample   | tvalid/tready
// m_axis      | out | tdata[33:0] filtered, tlast last_output  | tvalid/tready
// cfg         | in  | addr 0..6 selects coef_0..coef_6         | i_cfg_we, no wait
//
// One sample request per cycle sustained while the output is not stalled and
// no tail is running. A result passes the window register, product register,
// partial-sum register and output register in turn. A sample marked last
// starts a tail (input ready low) that feeds the final sample again to drain
// the centered outputs. Synchronous active-low reset clears valids, history
// and counters and loads the default coefficients. Output stall backs up
// through the pipeline stages combinationally into the input ready.
module fir_convolution_clamped_edges_unit
    import fcce_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // sample request: [15:0] sample
    input  wire logic [15:0]       i_s_axis_tdata,
    input  wire logic              i_s_axis_tvalid,
    input  wire logic              i_s_axis_tlast,
    output logic                   o_s_axis_tready,
    // result: [33:0] filtered, [39:34] zero
    output logic [39:0]            o_m_axis_tdata,
    output logic                   o_m_axis_tvalid,
    output logic                   o_m_axis_tlast,
    input  wire logic              i_m_axis_tready,
    input  wire logic              i_cfg_we,
    input  wire logic [ADDR_W-1:0] i_cfg_addr,
    input  wire logic [COEF_W-1:0] i_cfg_data
);

    logic [NUM_TAPS-1:0][COEF_W-1:0] r_coef;
    t_win                            w_win;
    t_stat                           w_stat;
    logic                            w_take;
    logic [SUM_W-1:0]                w_sum;

    // coefficient registers; indexes past the last tap are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RESET;
        end else if (i_cfg_we && (i_cfg_addr < ADDR_W'(NUM_TAPS))) begin
            r_coef[i_cfg_addr] <= i_cfg_data;
        end
    end

    fcce_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_sample (i_s_axis_tdata),
        .i_final  (i_s_axis_tlast),
        .o_ready  (o_s_axis_tready),
        .i_take   (w_take),
        .o_win    (w_win),
        .o_stat   (w_stat)
    );

    fcce_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (r_coef),
        .i_win   (w_win),
        .o_take  (w_take),
        .o_valid (o_m_axis_tvalid),
        .o_last  (o_m_axis_tlast),
        .o_sum   (w_sum),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {6'b0, w_sum};

`ifndef NO_ASSERTIONS
    // output pipe is empty in the cycle after a reset edge
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // a final sample request starts the tail, which blocks new requests
    a_fin_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |=> !o_s_axis_tready)
        else $error("request taken right after a final sample");

    a_flush_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.flush |-> !o_s_axis_tready)
        else $error("input ready while draining tail");
`endif

endmodule
`default_nettype wire

### tb/sv/tb_fir_convolution_clamped_edges_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_fir_convolution_clamped_edges_unit;
    import fcce_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RST_CYCLES   = 5;
    // pipeline is four deep plus the tail; leave plenty of margin
    localparam int DRAIN_CYCLES = 16;
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int MAX_PRINTS   = 200;

    // register map: coef_0..coef_6 at 0..6, index 7 decodes to nothing
    localparam logic [ADDR_W-1:0] COEF0_IDX = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] SPARE_IDX = ADDR_W'(7);

    localparam logic [SMP_W-1:0] SMP_MAX = 16'h7FFF;
    localparam logic [SMP_W-1:0] SMP_MIN = 16'h8000;

    typedef struct {
        logic signed [SMP_W-1:0] value;
        logic                    fin;
    } t_smp_req;

    typedef struct {
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } t_filt_res;

    // ---------------------------------------------------------------
    // DUT hookup
    // ---------------------------------------------------------------
    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic [15:0]        i_s_axis_tdata  = '0;  // [15:0] sample
    logic               i_s_axis_tvalid = 1'b0;
    logic               i_s_axis_tlast  = 1'b0;
    logic               o_s_axis_tready;
    logic [39:0]        o_m_axis_tdata;        // [33:0] filtered, [39:34] zero
    logic               o_m_axis_tvalid;
    logic               o_m_axis_tlast;
    logic               i_m_axis_tready = 1'b0;
    logic               i_cfg_we        = 1'b0;
    logic [ADDR_W-1:0]  i_cfg_addr      = '0;
    logic [COEF_W-1:0]  i_cfg_data      = '0;

    fir_convolution_clamped_edges_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Filter predictor: own copy of taps, sample history and run count
    // ---------------------------------------------------------------
    logic signed [COEF_W-1:0] tap_w    [NUM_TAPS];
    logic signed [SMP_W-1:0]  win_hist [HIST_DEPTH];  // [0] oldest
    logic [CNT_W-1:0]         seen;

    t_smp_req  sample_q[$];     // requests waiting for the sender
    t_filt_res filtered_q[$];   // predicted outputs, oldest first

    int  mismatch_cnt = 0;
    int  stall_odds   = 0;      // idle-burst chance out of 16, both sides
    bit  rst_done     = 1'b0;
    bit  smp_taken    = 1'b0;   // request accepted at the last rising edge
    int  s_gap        = 0;
    int  m_gap        = 0;
    t_smp_req cur_req;

    // Full-precision window sum over history plus the new sample, then
    // shift the new sample in. 7 x 2^30 fits in 34 signed bits.
    function automatic logic signed [SUM_W-1:0] shift_and_sum(
        input logic signed [SMP_W-1:0] x
    );
        longint acc;
        acc = 0;
        for (int t = 0; t < HIST_DEPTH; t++)
            acc += longint'(tap_w[t]) * longint'(win_hist[t]);
        acc += longint'(tap_w[NUM_TAPS-1]) * longint'(x);
        for (int t = 0; t < HIST_DEPTH - 1; t++)
            win_hist[t] = win_hist[t+1];
        win_hist[HIST_DEPTH-1] = x;
        return SUM_W'(acc);
    endfunction

    // Output for position n-3 on each sample with n >= 3; the final sample repeats
    // itself three more times to flush, marking the last one.
    task automatic predict_filtered(input t_smp_req r);
        logic [CNT_W-1:0] c;
        t_filt_res        res;
        c = seen;
        // first sample of a run clamps the left edge
        if (c == '0) begin
            foreach (win_hist[k]) win_hist[k] = r.value;
        end
        res.sum  = shift_and_sum(r.value);
        res.last = 1'b0;
        if (c >= HALF_CNT) filtered_q.push_back(res);
        if (r.fin) begin
            // right edge clamp: short runs only emit positions >= 0
            for (int k = 1; k <= HALF_WIN; k++) begin
                res.sum  = shift_and_sum(r.value);
                res.last = (k == HALF_WIN);
                if (int'(c) + k >= HALF_WIN) filtered_q.push_back(res);
            end
            seen = '0;
        end else if (c < SAT_CNT) begin
            seen = c + 1'b1;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
        mismatch_cnt++;
        // cap the log so a badly broken build stays readable
        if (mismatch_cnt <= MAX_PRINTS)
            $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // Sample sender: falling edge, holds a request until it is taken
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rst_done && !(i_s_axis_tvalid && !smp_taken)) begin
            if (s_gap != 0) begin
                s_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (sample_q.size() != 0 && $urandom_range(0, 15) < stall_odds) begin
                s_gap = $urandom_range(1, 13) - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                cur_req = sample_q.pop_front();
                i_s_axis_tdata  <= cur_req.value;
                i_s_axis_tlast  <= cur_req.fin;
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver backpressure, same burst pattern
    always @(negedge i_clk) begin
        if (m_gap != 0) begin
            m_gap--;
            i_m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 15) < stall_odds) begin
            m_gap = $urandom_range(1, 13) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Accepted sample requests feed the predictor
    always @(posedge i_clk) begin
        t_smp_req r;
        smp_taken = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (smp_taken) begin
            r.value = i_s_axis_tdata;
            r.fin   = i_s_axis_tlast;
            predict_filtered(r);
        end
    end

    // Accepted results are checked against the oldest prediction
    always @(posedge i_clk) begin
        t_filt_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (filtered_q.size() == 0) begin
                flag_mismatch("unexpected result", o_m_axis_tdata, '0);
            end else begin
                want = filtered_q.pop_front();
                if (o_m_axis_tdata !== {6'b0, want.sum})
                    flag_mismatch("filtered", o_m_axis_tdata, {6'b0, want.sum});
                if (o_m_axis_tlast !== want.last)
                    flag_mismatch("last_output", 40'(o_m_axis_tlast), 40'(want.last));
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_req(input logic [SMP_W-1:0] v, input logic fin);
        t_smp_req r;
        r.value = v;
        r.fin   = fin;
        sample_q.push_back(r);
    endtask

    task automatic write_coef(input logic [ADDR_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        // unmapped index is dropped by the block
        if (idx < NUM_TAPS) tap_w[idx] = val;
    endtask

    // rnd=0: every tap gets fill; rnd=1: random taps, extremes favored
    task automatic load_taps(input bit rnd, input logic [COEF_W-1:0] fill);
        logic [COEF_W-1:0] v;
        for (int i = 0; i < NUM_TAPS; i++) begin
            v = fill;
            if (rnd) begin
                case ($urandom_range(0, 5))
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = '0;
                    default: v = COEF_W'($urandom);
                endcase
            end
            write_coef(COEF0_IDX + ADDR_W'(i), v);
        end
        write_coef(SPARE_IDX, COEF_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return SMP_W'($urandom_range(0, 15) - 8);
            default: return SMP_W'($urandom);
        endcase
    endfunction

    // Whole runs until at least n samples are queued; mostly mid-length,
    // some shorter than the window, a few long; runs of five or more saturate the count.
    task automatic queue_runs(input int n);
        int total;
        int len;
        total = 0;
        while (total < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2: len = $urandom_range(1, 4);
                9:       len = $urandom_range(17, 48);
                default: len = $urandom_range(5, 16);
            endcase
            for (int i = 0; i < len; i++)
                push_req(pick_sample(), i == len - 1);
            total += len;
        end
    endtask

    // Idle point: everything sent and every prediction checked
    task automatic drain();
        while (sample_q.size() != 0 || i_s_axis_tvalid || filtered_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        foreach (tap_w[i]) tap_w[i] = COEF_RESET[i];
        foreach (win_hist[i]) win_hist[i] = '0;
        seen = '0;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done <= 1'b1;

        // Directed, default taps: single-sample runs at both extremes,
        // then runs of two to four samples, all shorter than the window.
        stall_odds = 3;
        push_req(SMP_MAX, 1'b1);
        push_req(SMP_MIN, 1'b1);
        push_req(16'h0000, 1'b0);
        push_req(16'hFFFF, 1'b1);
        push_req(16'h0001, 1'b0);
        push_req(16'h0002, 1'b0);
        push_req(16'h0003, 1'b1);
        push_req(16'h5555, 1'b0);
        push_req(16'hAAAA, 1'b0);
        push_req(16'h0064, 1'b0);
        push_req(16'hFF9C, 1'b1);
        drain();

        // Largest positive sum: every tap and sample at the negative extreme
        load_taps(1'b0, 16'h8000);
        repeat (4) push_req(SMP_MIN, 1'b0);
        push_req(SMP_MIN, 1'b1);
        drain();

        // Positive-extreme taps across a step from the negative to the positive sample extreme
        load_taps(1'b0, 16'h7FFF);
        repeat (3) push_req(SMP_MIN, 1'b0);
        push_req(SMP_MAX, 1'b1);
        drain();

        // Random phases with varying idle pressure
        load_taps(1'b1, '0);
        stall_odds = 4;
        queue_runs(80);
        drain();

        load_taps(1'b1, '0);
        stall_odds = 8;
        queue_runs(80);
        drain();

        load_taps(1'b1, '0);
        stall_odds = 2;
        queue_runs(80);
        drain();

        load_taps(1'b1, '0);
        stall_odds = 12;
        queue_runs(70);
        drain();

        // closing stretch at full rate, no idling either side
        load_taps(1'b1, '0);
        stall_odds = 0;
        queue_runs(70);
        drain();

        if (mismatch_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: a hung handshake or missing results end here
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
